// File: sv/trbps_pkg.sv
package trbps_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int VALUE_BITS = 20;
    localparam int FRAC_BITS  = 8;
    localparam int DEPTH      = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int DIM_W      = 7;
    localparam int IDX_W      = 12;
    localparam int SWEEP_W    = 16;
    localparam int RES_W      = 40;
    localparam int PIX_W      = 8;
    localparam int SUM_W      = VALUE_BITS + 3;
    localparam int DIFF_W     = SUM_W + 1;
    localparam int CH_N       = 3;
    localparam int WORD_W     = CH_N * VALUE_BITS;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_RUN  = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_ROWS = 2'd0,
        CFG_COLS = 2'd1,
        CFG_TILE = 2'd2,
        CFG_NONE = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        RK_RESIDUAL = 1'b0,
        RK_PIXEL    = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_OUT,
        ST_TILE,
        ST_TADV,
        ST_PIX,
        ST_STEP,
        ST_PADV
    } state_t;

    typedef enum logic [2:0] {
        STP_CENTRE,
        STP_UP,
        STP_LEFT,
        STP_RIGHT,
        STP_DOWN,
        STP_LAST,
        STP_WRITE
    } step_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              rd_en;
        logic              load_wr;
        logic              clr_wr;
        logic              acc_init;
        logic              acc_add;
        logic              upd_wr;
        logic              res_clear;
        logic              res_add;
        logic              out_read;
        logic              out_run;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

// File: sv/trbps_datapath.sv
module trbps_datapath
    import trbps_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  dp_cmd_t                      cmd,
    output dp_status_t                   status,
    input  logic [IDX_W-1:0]             s_pixel_index,
    input  logic                         s_mask_bit,
    input  logic signed [VALUE_BITS-1:0] s_start_red,
    input  logic signed [VALUE_BITS-1:0] s_start_green,
    input  logic signed [VALUE_BITS-1:0] s_start_blue,
    input  logic signed [VALUE_BITS-1:0] s_grad_red,
    input  logic signed [VALUE_BITS-1:0] s_grad_green,
    input  logic signed [VALUE_BITS-1:0] s_grad_blue,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_result_kind,
    output logic [PIX_W-1:0]             m_pixel_red,
    output logic [PIX_W-1:0]             m_pixel_green,
    output logic [PIX_W-1:0]             m_pixel_blue,
    output logic [RES_W-1:0]             m_residual_red,
    output logic [RES_W-1:0]             m_residual_green,
    output logic [RES_W-1:0]             m_residual_blue
);

    localparam logic signed [SUM_W-1:0] VMAX = SUM_W'((1 << (VALUE_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] VMIN = -VMAX - SUM_W'(1);

    logic [WORD_W-1:0] img_mem  [DEPTH];
    logic [WORD_W-1:0] grad_mem [DEPTH];
    logic              mask_mem [DEPTH];

    logic [WORD_W-1:0] img_rd_reg;
    logic [WORD_W-1:0] grad_rd_reg;
    logic              mask_rd_reg;

    logic signed [SUM_W-1:0]      nsum_reg   [CH_N];
    logic signed [VALUE_BITS-1:0] centre_reg [CH_N];
    logic                         mask_q_reg;
    logic [RES_W-1:0]             res_reg    [CH_N];

    logic                         m_valid_reg;
    logic                         kind_reg;
    logic [PIX_W-1:0]             pix_reg    [CH_N];
    logic [RES_W-1:0]             rout_reg   [CH_N];

    logic [ADDR_W-1:0]            wr_addr;
    logic [WORD_W-1:0]            img_wdata;
    logic                         img_we;
    logic [WORD_W-1:0]            upd_word;
    logic [PIX_W-1:0]             clip_val   [CH_N];
    logic [RES_W-1:0]             res_next   [CH_N];

    assign wr_addr   = cmd.load_wr ? ADDR_W'(s_pixel_index) : cmd.addr;
    assign img_we    = cmd.load_wr || (cmd.upd_wr && mask_q_reg);
    assign img_wdata = cmd.load_wr ? {s_start_blue, s_start_green, s_start_red} : upd_word;

    always_comb begin
        logic signed [SUM_W-1:0]         q;
        logic signed [DIFF_W-1:0]        d;
        logic [DIFF_W-1:0]               a;
        logic [RES_W:0]                  s;
        logic signed [VALUE_BITS-1:0]    v;
        logic [VALUE_BITS-FRAC_BITS-1:0] w;
        for (int ch = 0; ch < CH_N; ch++) begin
            // Floor division by four is an arithmetic shift.
            q = nsum_reg[ch] >>> 2;
            if (q > VMAX) begin
                upd_word[ch*VALUE_BITS +: VALUE_BITS] = VMAX[VALUE_BITS-1:0];
            end else if (q < VMIN) begin
                upd_word[ch*VALUE_BITS +: VALUE_BITS] = VMIN[VALUE_BITS-1:0];
            end else begin
                upd_word[ch*VALUE_BITS +: VALUE_BITS] = q[VALUE_BITS-1:0];
            end

            d = DIFF_W'(nsum_reg[ch]) - (DIFF_W'(centre_reg[ch]) <<< 2);
            a = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
            s = {1'b0, res_reg[ch]} + (RES_W + 1)'(a);
            res_next[ch] = s[RES_W] ? {RES_W{1'b1}} : s[RES_W-1:0];

            v = img_rd_reg[ch*VALUE_BITS +: VALUE_BITS];
            w = v[VALUE_BITS-1:FRAC_BITS];
            if (v[VALUE_BITS-1]) begin
                clip_val[ch] = '0;
            end else if (w > (VALUE_BITS-FRAC_BITS)'(255)) begin
                clip_val[ch] = 8'd255;
            end else begin
                clip_val[ch] = w[PIX_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (img_we) begin
            img_mem[wr_addr] <= img_wdata;
        end
        if (cmd.load_wr) begin
            grad_mem[wr_addr] <= {s_grad_blue, s_grad_green, s_grad_red};
        end
        if (cmd.load_wr || cmd.clr_wr) begin
            mask_mem[wr_addr] <= cmd.load_wr ? s_mask_bit : 1'b0;
        end
        if (cmd.rd_en) begin
            img_rd_reg  <= img_mem[cmd.addr];
            grad_rd_reg <= grad_mem[cmd.addr];
            mask_rd_reg <= mask_mem[cmd.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc_init) begin
            mask_q_reg <= mask_rd_reg;
        end
        for (int ch = 0; ch < CH_N; ch++) begin
            if (cmd.acc_init) begin
                nsum_reg[ch]   <= SUM_W'(signed'(grad_rd_reg[ch*VALUE_BITS +: VALUE_BITS]));
                centre_reg[ch] <= img_rd_reg[ch*VALUE_BITS +: VALUE_BITS];
            end else if (cmd.acc_add) begin
                nsum_reg[ch] <= nsum_reg[ch] +
                    SUM_W'(signed'(img_rd_reg[ch*VALUE_BITS +: VALUE_BITS]));
            end
            if (cmd.res_clear) begin
                res_reg[ch] <= '0;
            end else if (cmd.res_add && mask_q_reg) begin
                res_reg[ch] <= res_next[ch];
            end
            if (cmd.out_read) begin
                pix_reg[ch]  <= clip_val[ch];
                rout_reg[ch] <= '0;
            end else if (cmd.out_run) begin
                pix_reg[ch]  <= '0;
                rout_reg[ch] <= res_reg[ch];
            end
        end
        if (cmd.out_read) begin
            kind_reg <= RK_PIXEL;
        end else if (cmd.out_run) begin
            kind_reg <= RK_RESIDUAL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_read || cmd.out_run) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid          = m_valid_reg;
    assign m_result_kind    = kind_reg;
    assign m_pixel_red      = pix_reg[0];
    assign m_pixel_green    = pix_reg[1];
    assign m_pixel_blue     = pix_reg[2];
    assign m_residual_red   = rout_reg[0];
    assign m_residual_green = rout_reg[1];
    assign m_residual_blue  = rout_reg[2];

endmodule

// File: sv/trbps_ctrl.sv
module trbps_ctrl
    import trbps_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [DIM_W-1:0]   cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [IDX_W-1:0]   s_pixel_index,
    input  logic [SWEEP_W-1:0] s_sweep_count,
    input  dp_status_t         status,
    output dp_cmd_t            cmd
);

    state_t             state_reg, state_next;
    step_t              step_reg, step_next;
    logic [DIM_W-1:0]   rows_cfg_reg, cols_cfg_reg, tile_cfg_reg;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic [SWEEP_W-1:0] sweep_reg, sweep_next;
    logic               phase_reg, phase_next;
    logic               par_reg, par_next;
    logic               rowpar_reg, rowpar_next;
    logic               resid_reg, resid_next;
    logic [DIM_W-1:0]   r0_reg, r0_next, c0_reg, c0_next;
    logic [DIM_W-1:0]   x_reg, x_next, y_reg, y_next;
    logic [ADDR_W-1:0]  id_reg, id_next;

    logic [DIM_W-1:0]   rows_u, cols_u, te_u, r1, c1;
    logic [DIM_W:0]     r_end, c_end;
    logic [2*DIM_W-1:0] id_full;
    logic               border, accept;

    always_comb begin
        if (rows_cfg_reg < DIM_W'(3)) begin
            rows_u = DIM_W'(3);
        end else if (rows_cfg_reg > DIM_W'(MAX_ROWS)) begin
            rows_u = DIM_W'(MAX_ROWS);
        end else begin
            rows_u = rows_cfg_reg;
        end
        if (cols_cfg_reg < DIM_W'(3)) begin
            cols_u = DIM_W'(3);
        end else if (cols_cfg_reg > DIM_W'(MAX_COLS)) begin
            cols_u = DIM_W'(MAX_COLS);
        end else begin
            cols_u = cols_cfg_reg;
        end
        te_u = (tile_cfg_reg == '0) ? DIM_W'(1) : tile_cfg_reg;
    end

    assign r_end = {1'b0, r0_reg} + {1'b0, te_u};
    assign c_end = {1'b0, c0_reg} + {1'b0, te_u};
    // The residual pass treats the whole image as a single tile.
    assign r1 = (resid_reg || r_end >= {1'b0, rows_u}) ? rows_u : r_end[DIM_W-1:0];
    assign c1 = (resid_reg || c_end >= {1'b0, cols_u}) ? cols_u : c_end[DIM_W-1:0];

    assign id_full = x_reg * cols_u + (2*DIM_W)'(y_reg);
    assign border  = (x_reg == '0) || (x_reg == rows_u - DIM_W'(1)) ||
                     (y_reg == '0) || (y_reg == cols_u - DIM_W'(1));

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= DIM_W'(64);
            cols_cfg_reg <= DIM_W'(64);
            tile_cfg_reg <= DIM_W'(8);
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ROWS: rows_cfg_reg <= cfg_wdata;
                CFG_COLS: cols_cfg_reg <= cfg_wdata;
                CFG_TILE: tile_cfg_reg <= cfg_wdata;
                CFG_NONE: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
        step_reg   <= step_next;
        sweep_reg  <= sweep_next;
        phase_reg  <= phase_next;
        par_reg    <= par_next;
        rowpar_reg <= rowpar_next;
        resid_reg  <= resid_next;
        r0_reg     <= r0_next;
        c0_reg     <= c0_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        id_reg     <= id_next;
    end

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        clr_next    = clr_reg;
        sweep_next  = sweep_reg;
        phase_next  = phase_reg;
        par_next    = par_reg;
        rowpar_next = rowpar_reg;
        resid_next  = resid_reg;
        r0_next     = r0_reg;
        c0_next     = c0_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        id_next     = id_reg;
        cmd         = '0;
        cmd.addr    = id_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                // Mask store is swept to zero once after reset.
                cmd.addr   = clr_reg;
                cmd.clr_wr = 1'b1;
                clr_next   = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (op_t'(s_op))
                        OP_LOAD: cmd.load_wr = 1'b1;
                        OP_RUN: begin
                            cmd.res_clear = 1'b1;
                            sweep_next    = s_sweep_count;
                            phase_next    = 1'b0;
                            par_next      = 1'b0;
                            rowpar_next   = 1'b0;
                            r0_next       = '0;
                            c0_next       = '0;
                            x_next        = '0;
                            y_next        = '0;
                            if (s_sweep_count == '0) begin
                                resid_next = 1'b1;
                                state_next = ST_PIX;
                            end else begin
                                resid_next = 1'b0;
                                state_next = ST_TILE;
                            end
                        end
                        OP_READ: begin
                            cmd.addr   = ADDR_W'(s_pixel_index);
                            cmd.rd_en  = 1'b1;
                            state_next = ST_RD_OUT;
                        end
                        OP_NONE: ;
                    endcase
                end
            end
            ST_RD_OUT: begin
                if (status.out_free) begin
                    cmd.out_read = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_TILE: begin
                if (par_reg == phase_reg) begin
                    x_next     = r0_reg;
                    y_next     = c0_reg;
                    state_next = ST_PIX;
                end else begin
                    state_next = ST_TADV;
                end
            end
            ST_TADV: begin
                state_next = ST_TILE;
                if (c_end < {1'b0, cols_u}) begin
                    c0_next  = c_end[DIM_W-1:0];
                    par_next = !par_reg;
                end else if (r_end < {1'b0, rows_u}) begin
                    r0_next     = r_end[DIM_W-1:0];
                    c0_next     = '0;
                    rowpar_next = !rowpar_reg;
                    par_next    = !rowpar_reg;
                end else begin
                    r0_next     = '0;
                    c0_next     = '0;
                    par_next    = 1'b0;
                    rowpar_next = 1'b0;
                    if (!phase_reg) begin
                        phase_next = 1'b1;
                    end else if (sweep_reg > SWEEP_W'(1)) begin
                        sweep_next = sweep_reg - SWEEP_W'(1);
                        phase_next = 1'b0;
                    end else begin
                        resid_next = 1'b1;
                        x_next     = '0;
                        y_next     = '0;
                        state_next = ST_PIX;
                    end
                end
            end
            ST_PIX: begin
                id_next = id_full[ADDR_W-1:0];
                if (border) begin
                    state_next = ST_PADV;
                end else begin
                    step_next  = STP_CENTRE;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                // Read data is registered and arrives in the cycle after its address.
                cmd.rd_en = 1'b1;
                unique case (step_reg)
                    STP_CENTRE: begin
                        cmd.addr  = id_reg;
                        step_next = STP_UP;
                    end
                    STP_UP: begin
                        cmd.addr     = id_reg - ADDR_W'(cols_u);
                        cmd.acc_init = 1'b1;
                        step_next    = STP_LEFT;
                    end
                    STP_LEFT: begin
                        cmd.addr    = id_reg - ADDR_W'(1);
                        cmd.acc_add = 1'b1;
                        step_next   = STP_RIGHT;
                    end
                    STP_RIGHT: begin
                        cmd.addr    = id_reg + ADDR_W'(1);
                        cmd.acc_add = 1'b1;
                        step_next   = STP_DOWN;
                    end
                    STP_DOWN: begin
                        cmd.addr    = id_reg + ADDR_W'(cols_u);
                        cmd.acc_add = 1'b1;
                        step_next   = STP_LAST;
                    end
                    STP_LAST: begin
                        cmd.rd_en   = 1'b0;
                        cmd.acc_add = 1'b1;
                        step_next   = STP_WRITE;
                    end
                    STP_WRITE: begin
                        cmd.rd_en   = 1'b0;
                        cmd.upd_wr  = !resid_reg;
                        cmd.res_add = resid_reg;
                        state_next  = ST_PADV;
                    end
                    default: state_next = ST_PADV;
                endcase
            end
            ST_PADV: begin
                if ({1'b0, y_reg} + (DIM_W+1)'(1) < {1'b0, c1}) begin
                    y_next     = y_reg + DIM_W'(1);
                    state_next = ST_PIX;
                end else if ({1'b0, x_reg} + (DIM_W+1)'(1) < {1'b0, r1}) begin
                    x_next     = x_reg + DIM_W'(1);
                    y_next     = c0_reg;
                    state_next = ST_PIX;
                end else if (resid_reg) begin
                    if (status.out_free) begin
                        cmd.out_run = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end else begin
                    state_next = ST_TADV;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// File: sv/tiled_red_black_poisson_solver.sv
// Red-black Gauss-Seidel Poisson solver over square tiles, three colour channels.
// Input channel (s_valid/s_ready) carries one transaction per item: load writes one
// pixel (mask, start value, gradient), run performs s_sweep_count sweeps and returns
// the residual sums, read returns one pixel clipped to 0..255. Unknown ops are dropped.
// Output channel (m_valid/m_ready) carries one transaction for each run and read.
// A load is written when it is accepted, and s_ready stays high. A read first
// registers the memory word, then, once the output register is free, the clipped
// pixel. A run updates each interior pixel through one image memory read port,
// five reads per update, leaves the outer ring unchanged and ends with a residual pass.
// One item is worked on at a time; s_ready is high only while the block is idle.
// A finished result waits in the output register while the receiver stalls; loads
// are still accepted then, and a later run or read holds until the register frees.
// After reset the block clears all 4096 entries of the mask store, with s_ready
// low; configuration writes are taken throughout. Registers reset to 64 rows,
// 64 columns and a tile edge of 8; they must only be written while idle.
module tiled_red_black_poisson_solver
    import trbps_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [1:0]                   cfg_index,
    input  logic [DIM_W-1:0]             cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_op,
    input  logic [IDX_W-1:0]             s_pixel_index,
    input  logic                         s_mask_bit,
    input  logic signed [VALUE_BITS-1:0] s_start_red,
    input  logic signed [VALUE_BITS-1:0] s_start_green,
    input  logic signed [VALUE_BITS-1:0] s_start_blue,
    input  logic signed [VALUE_BITS-1:0] s_grad_red,
    input  logic signed [VALUE_BITS-1:0] s_grad_green,
    input  logic signed [VALUE_BITS-1:0] s_grad_blue,
    input  logic [SWEEP_W-1:0]           s_sweep_count,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_result_kind,
    output logic [PIX_W-1:0]             m_pixel_red,
    output logic [PIX_W-1:0]             m_pixel_green,
    output logic [PIX_W-1:0]             m_pixel_blue,
    output logic [RES_W-1:0]             m_residual_red,
    output logic [RES_W-1:0]             m_residual_green,
    output logic [RES_W-1:0]             m_residual_blue
);

    dp_cmd_t    cmd;
    dp_status_t status;

    trbps_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_pixel_index (s_pixel_index),
        .s_sweep_count (s_sweep_count),
        .status        (status),
        .cmd           (cmd)
    );

    trbps_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_pixel_index    (s_pixel_index),
        .s_mask_bit       (s_mask_bit),
        .s_start_red      (s_start_red),
        .s_start_green    (s_start_green),
        .s_start_blue     (s_start_blue),
        .s_grad_red       (s_grad_red),
        .s_grad_green     (s_grad_green),
        .s_grad_blue      (s_grad_blue),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_pixel_red      (m_pixel_red),
        .m_pixel_green    (m_pixel_green),
        .m_pixel_blue     (m_pixel_blue),
        .m_residual_red   (m_residual_red),
        .m_residual_green (m_residual_green),
        .m_residual_blue  (m_residual_blue)
    );

endmodule

// File: verif/tb_tiled_red_black_poisson_solver.sv
module tb_tiled_red_black_poisson_solver;
    import trbps_pkg::*;

    typedef struct {
        kind_t      kind;
        logic [7:0]  pix [3];
        logic [39:0] res [3];
    } solver_result_t;

    typedef struct {
        op_t                          op;
        logic [IDX_W-1:0]             idx;
        logic                         mask;
        logic signed [VALUE_BITS-1:0] start [3];
        logic signed [VALUE_BITS-1:0] grad [3];
        logic [SWEEP_W-1:0]           sweeps;
        bit                           typed;
        solver_result_t               want;
    } solver_item_t;

    localparam longint RES_SAT = (64'd1 << 40) - 1;
    localparam int     VMAX    = (1 << (VALUE_BITS - 1)) - 1;
    localparam int     VMIN    = -VMAX - 1;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = CFG_ROWS;
    logic [DIM_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_op = OP_LOAD;
    logic [IDX_W-1:0] s_pixel_index = '0;
    logic s_mask_bit = 1'b0;
    logic signed [VALUE_BITS-1:0] s_start_red = '0, s_start_green = '0, s_start_blue = '0;
    logic signed [VALUE_BITS-1:0] s_grad_red = '0, s_grad_green = '0, s_grad_blue = '0;
    logic [SWEEP_W-1:0] s_sweep_count = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_result_kind;
    logic [PIX_W-1:0] m_pixel_red, m_pixel_green, m_pixel_blue;
    logic [RES_W-1:0] m_residual_red, m_residual_green, m_residual_blue;

    tiled_red_black_poisson_solver i_dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Shadow of the solver state.
    int img [DEPTH][3];
    int grd [DEPTH][3];
    bit msk [DEPTH];
    bit written [DEPTH];
    logic [DIM_W-1:0] rows_reg = 7'd64, cols_reg = 7'd64, tile_reg = 7'd8;

    solver_result_t pending_results [$];
    int errors = 0;
    int items_done = 0;
    int runs_done = 0;
    int reads_done = 0;
    int results_seen = 0;
    bit quiet = 1'b0;
    int long_hold = 0;

    function automatic int sat_value(longint v);
        if (v > VMAX) return VMAX;
        if (v < VMIN) return VMIN;
        return int'(v);
    endfunction

    function automatic longint around(int id, int cols, int ch);
        return longint'(grd[id][ch]) + img[id-cols][ch] + img[id-1][ch] + img[id+1][ch]
               + img[id+cols][ch];
    endfunction

    function automatic int used_dim(logic [DIM_W-1:0] v);
        if (v < 3) return 3;
        if (v > 64) return 64;
        return int'(v);
    endfunction

    function automatic void relax_tile(int r0, int r1, int c0, int c1, int rows, int cols);
        int id;
        for (int x = r0; x < r1; x++) begin
            if (x == 0 || x + 1 >= rows) continue;
            for (int y = c0; y < c1; y++) begin
                id = x * cols + y;
                if (y == 0 || y + 1 >= cols || !msk[id]) continue;
                for (int ch = 0; ch < 3; ch++)
                    img[id][ch] = sat_value(around(id, cols, ch) >>> 2);
            end
        end
    endfunction

    function automatic void solve_sweeps(int count, ref solver_result_t r);
        int rows, cols, te, tr, tc, id;
        longint d;
        longint acc [3];
        rows = used_dim(rows_reg);
        cols = used_dim(cols_reg);
        te = (tile_reg == 0) ? 1 : int'(tile_reg);
        tr = (rows + te - 1) / te;
        tc = (cols + te - 1) / te;
        for (int i = 0; i < count; i++)
            for (int ph = 0; ph < 2; ph++)
                for (int ti = 0; ti < tr; ti++)
                    for (int tj = 0; tj < tc; tj++)
                        if (((ti + tj) & 1) == ph)
                            relax_tile(ti * te, (ti * te + te < rows) ? ti * te + te : rows,
                                       tj * te, (tj * te + te < cols) ? tj * te + te : cols,
                                       rows, cols);
        acc = '{0, 0, 0};
        for (int x = 1; x + 1 < rows; x++)
            for (int y = 1; y + 1 < cols; y++) begin
                id = x * cols + y;
                if (!msk[id]) continue;
                for (int ch = 0; ch < 3; ch++) begin
                    d = around(id, cols, ch) - 4 * longint'(img[id][ch]);
                    if (d < 0) d = -d;
                    acc[ch] = (d > RES_SAT - acc[ch]) ? RES_SAT : acc[ch] + d;
                end
            end
        r.kind = RK_RESIDUAL;
        for (int ch = 0; ch < 3; ch++) begin
            r.pix[ch] = '0;
            r.res[ch] = acc[ch][39:0];
        end
    endfunction

    // Updates the shadow state; returns 1 when the item produces a result.
    function automatic bit solver_step(solver_item_t it, ref solver_result_t r);
        int v;
        case (it.op)
            OP_LOAD: begin
                msk[it.idx] = it.mask;
                written[it.idx] = 1'b1;
                for (int ch = 0; ch < 3; ch++) begin
                    img[it.idx][ch] = int'(it.start[ch]);
                    grd[it.idx][ch] = int'(it.grad[ch]);
                end
                return 1'b0;
            end
            OP_RUN: begin
                solve_sweeps(int'(it.sweeps), r);
                return 1'b1;
            end
            OP_READ: begin
                r.kind = RK_PIXEL;
                for (int ch = 0; ch < 3; ch++) begin
                    v = img[it.idx][ch];
                    r.pix[ch] = (v < 0) ? 8'd0 : ((v >>> FRAC_BITS) > 255) ? 8'd255
                                : 8'(v >>> FRAC_BITS);
                    r.res[ch] = '0;
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic send_item(solver_item_t it);
        solver_result_t r;
        int gap;
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_op <= it.op;
        s_pixel_index <= it.idx;
        s_mask_bit <= it.mask;
        s_start_red <= it.start[0];
        s_start_green <= it.start[1];
        s_start_blue <= it.start[2];
        s_grad_red <= it.grad[0];
        s_grad_green <= it.grad[1];
        s_grad_blue <= it.grad[2];
        s_sweep_count <= it.sweeps;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (solver_step(it, r))
            pending_results.push_back(it.typed ? it.want : r);
        if (it.op != OP_NONE) items_done++;
        if (it.op == OP_RUN) runs_done++;
        if (it.op == OP_READ) reads_done++;
    endtask

    task automatic drain_and_configure(int rows, int cols, int tile);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ROWS;
        cfg_wdata <= DIM_W'(rows);
        @(negedge aclk);
        cfg_index <= CFG_COLS;
        cfg_wdata <= DIM_W'(cols);
        @(negedge aclk);
        cfg_index <= CFG_TILE;
        cfg_wdata <= DIM_W'(tile);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        rows_reg = DIM_W'(rows);
        cols_reg = DIM_W'(cols);
        tile_reg = DIM_W'(tile);
    endtask

    function automatic logic signed [VALUE_BITS-1:0] rand_value();
        case ($urandom_range(0, 6))
            0: return VALUE_BITS'(VMAX);
            1: return VALUE_BITS'(VMIN);
            2: return '0;
            3, 4: return VALUE_BITS'(int'($urandom_range(0, 131071)) - 65536);
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    function automatic solver_item_t load_item(int idx, bit mask);
        solver_item_t it;
        it.op = OP_LOAD;
        it.idx = IDX_W'(idx);
        it.mask = mask;
        for (int ch = 0; ch < 3; ch++) begin
            it.start[ch] = rand_value();
            it.grad[ch] = rand_value();
        end
        it.sweeps = 16'($urandom);
        it.typed = 1'b0;
        return it;
    endfunction

    function automatic solver_item_t fixed_item(op_t op, int idx, bit mask, int sv, int gv,
                                                int sweeps);
        solver_item_t it;
        it = load_item(idx, mask);
        it.op = op;
        it.sweeps = SWEEP_W'(sweeps);
        for (int ch = 0; ch < 3; ch++) begin
            it.start[ch] = VALUE_BITS'(sv);
            it.grad[ch] = VALUE_BITS'(gv);
        end
        return it;
    endfunction

    function automatic solver_item_t typed_pixel(int idx, int p);
        solver_item_t it;
        it = fixed_item(OP_READ, idx, 1'b0, 0, 0, 0);
        it.typed = 1'b1;
        it.want.kind = RK_PIXEL;
        it.want.pix = '{8'(p), 8'(p), 8'(p)};
        it.want.res = '{40'd0, 40'd0, 40'd0};
        return it;
    endfunction

    function automatic solver_item_t typed_residual(longint s);
        solver_item_t it;
        it = fixed_item(OP_RUN, 0, 1'b0, 0, 0, 0);
        it.typed = 1'b1;
        it.want.kind = RK_RESIDUAL;
        it.want.pix = '{8'd0, 8'd0, 8'd0};
        it.want.res = '{s[39:0], s[39:0], s[39:0]};
        return it;
    endfunction

    task automatic cmp_field(string name, logic [39:0] want, logic [39:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        solver_result_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d", $time,
                         m_result_kind);
                errors++;
            end else begin
                w = pending_results.pop_front();
                results_seen++;
                cmp_field("result_kind", 40'(w.kind), 40'(m_result_kind));
                cmp_field("pixel_red", 40'(w.pix[0]), 40'(m_pixel_red));
                cmp_field("pixel_green", 40'(w.pix[1]), 40'(m_pixel_green));
                cmp_field("pixel_blue", 40'(w.pix[2]), 40'(m_pixel_blue));
                cmp_field("residual_red", w.res[0], m_residual_red);
                cmp_field("residual_green", w.res[1], m_residual_green);
                cmp_field("residual_blue", w.res[2], m_residual_blue);
            end
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin
        int burst;
        burst = 0;
        forever begin
            @(negedge aclk);
            if (long_hold > 0) begin
                m_ready <= 1'b0;
                long_hold--;
            end else if (burst > 0) begin
                m_ready <= 1'b0;
                burst--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                burst = $urandom_range(0, 13);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #(64'd8 * 64'd30_000_000);
        $display("[tiled_red_black_poisson_solver] ERROR");
        $finish;
    end

    initial begin
        solver_item_t table_rows [$];
        solver_item_t it;
        int rows, cols, n, pick, phase;

        for (int i = 0; i < DEPTH; i++) begin
            msk[i] = 1'b0;
            written[i] = 1'b0;
            for (int ch = 0; ch < 3; ch++) begin
                img[i][ch] = 0;
                grd[i][ch] = 0;
            end
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Register values below 3 are clamped, and a tile edge of zero acts as one.
        drain_and_configure(0, 2, 0);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_NONE;
        cfg_wdata <= 7'h7F;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;

        // 3x3 image: the centre is the only solved pixel, its neighbours sit at the maximum.
        for (int i = 0; i < 9; i++)
            table_rows.push_back(fixed_item(OP_LOAD, i, i == 4,
                (i == 4 || i == 8) ? 0 : (i % 2 == 1) ? VMAX : (i == 2 || i == 6) ? 256 : VMIN,
                (i == 4) ? VMAX : VMIN, 0));
        table_rows.push_back(fixed_item(OP_LOAD, 4095, 1'b0, 65535, 1, 0));
        table_rows.push_back(fixed_item(OP_LOAD, 2048, 1'b1, -1, VMAX, 0));
        table_rows.push_back(fixed_item(OP_NONE, 4095, 1'b1, 0, 0, 1));
        table_rows.push_back(typed_pixel(1, 255));
        table_rows.push_back(typed_pixel(2, 1));
        table_rows.push_back(typed_pixel(0, 0));
        table_rows.push_back(typed_pixel(4095, 255));
        table_rows.push_back(typed_pixel(2048, 0));
        table_rows.push_back(typed_residual(5 * longint'(VMAX)));
        table_rows.push_back(fixed_item(OP_RUN, 0, 1'b0, 0, 0, 1));
        table_rows.push_back(typed_pixel(4, 255));
        table_rows.push_back(typed_residual(longint'(VMAX)));
        table_rows.push_back(fixed_item(OP_RUN, 0, 1'b0, 0, 0, 16'hFFFF));
        table_rows.push_back(fixed_item(OP_READ, 4, 1'b0, 0, 0, 0));
        foreach (table_rows[i])
            send_item(table_rows[i]);

        phase = 0;
        while (items_done < 1800) begin
            phase++;
            case (phase)
                1: drain_and_configure(127, 3, 127);
                2: drain_and_configure(0, 127, 64);
                3: drain_and_configure(3, 64, 1);
                4: drain_and_configure(64, 3, 2);
                default: drain_and_configure($urandom_range(3, 9), $urandom_range(3, 9),
                                             $urandom_range(0, 5));
            endcase
            if (items_done > 1650) quiet = 1'b1;
            rows = used_dim(rows_reg);
            cols = used_dim(cols_reg);
            // Every address a run can touch gets a value before the first run.
            for (int i = 0; i < rows * cols; i++)
                if (!written[i] || $urandom_range(0, 3) == 0)
                    send_item(load_item(i, $urandom_range(0, 2) != 0));
            if (phase == 5) long_hold = 400;
            n = $urandom_range(60, 120);
            for (int k = 0; k < n; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    it = load_item($urandom_range(0, 3) == 0 ? $urandom_range(0, DEPTH - 1)
                                   : $urandom_range(0, rows * cols - 1),
                                   $urandom_range(0, 2) != 0);
                end else if (pick < 80) begin
                    it = load_item(0, 1'b0);
                    it.op = OP_READ;
                    do it.idx = IDX_W'($urandom_range(0, DEPTH - 1)); while (!written[it.idx]);
                    if ($urandom_range(0, 1)) it.idx = IDX_W'($urandom_range(0, rows * cols - 1));
                end else if (pick < 95) begin
                    it = load_item(0, 1'b0);
                    it.op = OP_RUN;
                    it.sweeps = (rows * cols > 60) ? SWEEP_W'($urandom_range(0, 3))
                                : SWEEP_W'($urandom_range(0, 20));
                end else begin
                    it = load_item($urandom_range(0, DEPTH - 1), 1'b1);
                    it.op = OP_NONE;
                end
                send_item(it);
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Covered %0d items (%0d runs, %0d reads) over %0d image shapes.",
                 items_done, runs_done, reads_done, phase + 1);
        $display("%0d results compared, %0d mismatches.", results_seen, errors);
        if (errors == 0) begin
            $display("[tiled_red_black_poisson_solver] OK");
        end else begin
            $display("[tiled_red_black_poisson_solver] ERROR");
        end
        $finish;
    end

endmodule
